>>> design/erp_pkg.sv
package erp_pkg;

   // Build-time sizing
   localparam int MAX_STEPS      = 32;
   localparam int BEAT_INT_BITS  = 24;
   localparam int BEAT_FRAC_BITS = 16;

   localparam int BEAT_W   = BEAT_INT_BITS + BEAT_FRAC_BITS;
   localparam int STEP_W   = $clog2(MAX_STEPS + 1);
   localparam int REM_W    = $clog2(2 * MAX_STEPS);
   localparam int IBEAT_W  = BEAT_INT_BITS + 1;
   localparam int PROD_W   = 2 * STEP_W;
   localparam int MOD_W    = (IBEAT_W > PROD_W) ? IBEAT_W : PROD_W;
   localparam int CNT_W    = $clog2(MOD_W + 1);
   localparam int TURN_W   = 16;
   localparam int ROT_W    = TURN_W + STEP_W;
   localparam int FSUM_W   = ROT_W + BEAT_FRAC_BITS + 1;
   localparam int CARRY_W  = FSUM_W - (BEAT_FRAC_BITS + TURN_W);

   // Register and field widths
   localparam int STEP_CSR_W   = 6;
   localparam int PULSE_CSR_W  = 6;
   localparam int CHANCE_W     = 17;
   localparam int FLAGS_W      = 3;
   localparam int MODE_W       = 2;
   localparam int PWORD_W      = 27;
   localparam int NWORD_W      = 11;
   localparam int CSR_DATA_W   = 27;
   localparam int CSR_IDX_W    = 3;
   localparam int PITCH_W      = 7;
   localparam int RAND_W       = 16;
   localparam int SPAN_W       = 8;
   localparam int CHAN_W       = 5;

   localparam int REQ_FIELDS_W = BEAT_W + 1 + PITCH_W + RAND_W + RAND_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = CHAN_W + PITCH_W + PITCH_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Reset values
   localparam logic [STEP_CSR_W-1:0]  STEP_RST   = 6'd16;
   localparam logic [PULSE_CSR_W-1:0] PULSE_RST  = 6'd4;
   localparam logic [TURN_W-1:0]      TURN_RST   = 16'd0;
   localparam logic [CHANCE_W-1:0]    CHANCE_RST = 17'd65536;
   localparam logic [FLAGS_W-1:0]     FLAGS_RST  = 3'd1;
   localparam logic [MODE_W-1:0]      MODE_RST   = 2'd0;
   localparam logic [PWORD_W-1:0]     PWORD_RST  = 27'd60;
   localparam logic [NWORD_W-1:0]     NWORD_RST  = 11'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_COUNT  = 3'd0,
      CSR_PULSE_COUNT = 3'd1,
      CSR_ROTATE_TURN = 3'd2,
      CSR_FIRE_CHANCE = 3'd3,
      CSR_VOICE_FLAGS = 3'd4,
      CSR_PITCH_MODE  = 3'd5,
      CSR_PITCH_WORD  = 3'd6,
      CSR_NOTE_WORD   = 3'd7
   } csr_index_type;

   typedef enum logic [MODE_W-1:0] {
      PITCH_FIXED    = 2'd0,
      PITCH_RELATIVE = 2'd1,
      PITCH_RANDOM   = 2'd2
   } pitch_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_CHECK,
      ST_MOD_IDX,
      ST_PROD,
      ST_MOD_ONSET,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_status_type;

   // Zero steps act as one, too many saturate
   function automatic logic [STEP_W-1:0] eff_steps(input logic [STEP_CSR_W-1:0] sc);
      logic [STEP_W-1:0] res;
      if (sc == '0) begin
         res = STEP_W'(1);
      end else if (int'(sc) > MAX_STEPS) begin
         res = STEP_W'(MAX_STEPS);
      end else begin
         res = STEP_W'(sc);
      end
      return res;
   endfunction

endpackage

>>> design/erp_serial_mod.sv
module erp_serial_mod (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [erp_pkg::MOD_W-1:0]    dividend,   // left-aligned, MSB first
   input  logic [erp_pkg::CNT_W-1:0]    bit_count,
   input  logic [erp_pkg::REM_W-1:0]    divisor,
   output logic [erp_pkg::REM_W-1:0]    remainder,
   output erp_pkg::mod_status_type      status
);
   import erp_pkg::*;

   logic [MOD_W-1:0] shift_ff, shift_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] trial;

   // Remainder stays below the divisor, so its top bit is always clear
   assign trial = {rem_ff[REM_W-2:0], shift_ff[MOD_W-1]};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = bit_count;
         run_in   = (bit_count != '0);
         done_in  = (bit_count == '0);
      end else if (run_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= divisor) ? (trial - divisor) : trial;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign remainder   = rem_ff;
   assign status.busy = run_ff;
   assign status.done = done_ff;

endmodule

>>> design/erp_pitch.sv
module erp_pitch (
   input  logic                          clock,
   input  logic [erp_pkg::MODE_W-1:0]    pitch_mode,
   input  logic [erp_pkg::PWORD_W-1:0]   pitch_word,
   input  logic [erp_pkg::PITCH_W-1:0]   reference_pitch,
   input  logic [erp_pkg::RAND_W-1:0]    pitch_random,
   output logic [erp_pkg::PITCH_W-1:0]   note_pitch
);
   import erp_pkg::*;

   logic [PITCH_W-1:0]         rnd_a, rnd_b, rnd_lo, rnd_hi;
   logic [SPAN_W-1:0]          span;
   logic [RAND_W+SPAN_W-1:0]   scaled_ff, scaled_in;
   logic signed [PITCH_W+1:0]  rel_sum;
   logic [PITCH_W-1:0]         rel_pitch;
   logic [PITCH_W-1:0]         rnd_pitch;

   assign rnd_a  = pitch_word[19:13];
   assign rnd_b  = pitch_word[26:20];
   assign rnd_lo = (rnd_b < rnd_a) ? rnd_b : rnd_a;
   assign rnd_hi = (rnd_b < rnd_a) ? rnd_a : rnd_b;
   assign span   = SPAN_W'(rnd_hi) - SPAN_W'(rnd_lo) + SPAN_W'(1);

   // Register the product; its inputs hold steady while a beat is in work
   assign scaled_in = (RAND_W+SPAN_W)'(pitch_random) * (RAND_W+SPAN_W)'(span);

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   // Scaled value is below span, so it fits the pitch width
   assign rnd_pitch = rnd_lo + scaled_ff[RAND_W +: PITCH_W];

   always_comb begin
      rel_sum = signed'({2'b00, reference_pitch})
              + signed'({{3{pitch_word[12]}}, pitch_word[12:7]});
      if (rel_sum < 0) begin
         rel_pitch = '0;
      end else if (rel_sum > signed'((PITCH_W+2)'(127))) begin
         rel_pitch = PITCH_W'(127);
      end else begin
         rel_pitch = rel_sum[PITCH_W-1:0];
      end
   end

   always_comb begin
      case (pitch_mode_type'(pitch_mode))
         PITCH_RELATIVE: note_pitch = rel_pitch;
         PITCH_RANDOM:   note_pitch = rnd_pitch;
         default:        note_pitch = pitch_word[PITCH_W-1:0];
      endcase
   end

endmodule

>>> design/euclidean_rhythm_trigger.sv
// Euclidean rhythm voice: one note-on per new integer beat at a pattern onset, if chance allows.
// Input channel req_*: one beat per host position update (beat position, solo flag,
// reference pitch, two random words). Result channel rsp_*: a note-on beat (channel,
// pitch, velocity); a beat that does not fire gives nothing on rsp_*.
// Configuration port csr_*: write enable, register index, data; write only while idle.
// A firing beat passes ST_MULT, ST_SUM and ST_CHECK; then the bit-serial remainder
// unit, one bit a cycle, runs once over the 25-bit integer beat (beat mod steps) and
// once over the 12-bit index product before the result shows on rsp_tvalid.
// A beat gated off by the voice flags retires after ST_MULT, a repeated beat after ST_CHECK.
// One beat is in work at a time, so a new beat is taken only once the last has retired.
// Reset (synchronous, active high) restores the register defaults, forgets the last
// beat and drops any result not yet taken.
// A stalled receiver holds the result in the output register; the next beat is still
// accepted and worked on, and waits before the output only if it fires too.
module euclidean_rhythm_trigger (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: beat_position, any_solo, reference_pitch, chance_random, pitch_random
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [erp_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata: note_channel, note_pitch, note_velocity, zero fill
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [erp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [erp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [erp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import erp_pkg::*;

   // Configuration registers
   logic [STEP_CSR_W-1:0]  step_count_ff;
   logic [PULSE_CSR_W-1:0] pulse_count_ff;
   logic [TURN_W-1:0]      rotate_turn_ff;
   logic [CHANCE_W-1:0]    fire_chance_ff;
   logic [FLAGS_W-1:0]     voice_flags_ff;
   logic [MODE_W-1:0]      pitch_mode_ff;
   logic [PWORD_W-1:0]     pitch_word_ff;
   logic [NWORD_W-1:0]     note_word_ff;

   // Captured beat
   logic [BEAT_W-1:0]      pos_ff;
   logic                   any_solo_ff;
   logic [PITCH_W-1:0]     ref_pitch_ff;
   logic [RAND_W-1:0]      chance_rnd_ff;
   logic [RAND_W-1:0]      pitch_rnd_ff;

   // Work registers
   state_type              state_ff, state_in;
   logic [ROT_W-1:0]       rot_prod_ff;
   logic [IBEAT_W-1:0]     ibeat_ff, ibeat_in;
   logic [IBEAT_W-1:0]     last_beat_ff;
   logic                   beat_seen_ff;
   logic [STEP_W-1:0]      idx_ff;
   logic                   fire_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]  rsp_tdata_ff;

   // Derived values
   logic [STEP_W-1:0]      steps;
   logic [STEP_W-1:0]      pulses;
   logic                   gated;
   logic                   repeat_beat;
   logic [FSUM_W-1:0]      frac_sum;
   logic [PROD_W-1:0]      idx_prod;
   logic                   out_free;
   logic [PITCH_W-1:0]     note_pitch;
   logic [CHAN_W-1:0]      note_channel;

   // Controls from the sequencer
   logic                   accept;
   logic                   mult_en;
   logic                   sum_en;
   logic                   beat_new;
   logic                   idx_load;
   logic                   onset_start;
   logic                   fire_load;
   logic                   emit_load;

   // Remainder unit
   logic                   mod_start;
   logic [MOD_W-1:0]       mod_dividend;
   logic [CNT_W-1:0]       mod_bits;
   logic [REM_W-1:0]       mod_rem;
   mod_status_type         mod_status;

   assign steps  = eff_steps(step_count_ff);
   assign pulses = (int'(pulse_count_ff) > int'(steps)) ? steps : STEP_W'(pulse_count_ff);

   // Voice gated off: not enabled, muted, or someone else soloed
   assign gated = !voice_flags_ff[0] || voice_flags_ff[1] || (any_solo_ff && !voice_flags_ff[2]);

   assign repeat_beat = beat_seen_ff && (ibeat_ff == last_beat_ff);

   // Fraction plus rotation offset; the carry out is added to the integer beat
   assign frac_sum = (FSUM_W'(pos_ff[BEAT_FRAC_BITS-1:0]) << TURN_W)
                   + (FSUM_W'(rot_prod_ff) << BEAT_FRAC_BITS);
   assign ibeat_in = IBEAT_W'(pos_ff[BEAT_W-1:BEAT_FRAC_BITS])
                   + IBEAT_W'(frac_sum[FSUM_W-1 -: CARRY_W]);

   assign idx_prod = PROD_W'(idx_ff) * PROD_W'(pulses);

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_MULT;
         ST_MULT:      state_in = gated ? ST_IDLE : ST_SUM;
         ST_SUM:       state_in = ST_CHECK;
         ST_CHECK:     state_in = repeat_beat ? ST_IDLE : ST_MOD_IDX;
         ST_MOD_IDX:   if (mod_status.done) state_in = ST_PROD;
         ST_PROD:      state_in = ST_MOD_ONSET;
         ST_MOD_ONSET: if (mod_status.done) state_in = ST_EMIT;
         ST_EMIT:      if (!fire_ff || out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      mult_en     = 1'b0;
      sum_en      = 1'b0;
      beat_new    = 1'b0;
      idx_load    = 1'b0;
      onset_start = 1'b0;
      fire_load   = 1'b0;
      emit_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready  = 1'b1;
         ST_MULT:      mult_en     = !gated;
         ST_SUM:       sum_en      = 1'b1;
         ST_CHECK:     beat_new    = !repeat_beat;
         ST_MOD_IDX:   idx_load    = mod_status.done;
         ST_PROD:      onset_start = 1'b1;
         ST_MOD_ONSET: fire_load   = mod_status.done;
         ST_EMIT:      emit_load   = fire_ff && out_free;
         default:      req_tready  = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Feed the remainder unit: first beat mod steps, then index product mod steps
   assign mod_start    = beat_new || onset_start;
   assign mod_dividend = onset_start ? (MOD_W'(idx_prod) << (MOD_W - PROD_W))
                                     : (MOD_W'(ibeat_ff) << (MOD_W - IBEAT_W));
   assign mod_bits     = onset_start ? CNT_W'(PROD_W) : CNT_W'(IBEAT_W);

   erp_serial_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .bit_count (mod_bits),
      .divisor   (REM_W'(steps)),
      .remainder (mod_rem),
      .status    (mod_status)
   );

   erp_pitch u_pitch (
      .clock           (clock),
      .pitch_mode      (pitch_mode_ff),
      .pitch_word      (pitch_word_ff),
      .reference_pitch (ref_pitch_ff),
      .pitch_random    (pitch_rnd_ff),
      .note_pitch      (note_pitch)
   );

   assign note_channel = CHAN_W'(note_word_ff[10:7]) + CHAN_W'(1);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff  <= STEP_RST;
         pulse_count_ff <= PULSE_RST;
         rotate_turn_ff <= TURN_RST;
         fire_chance_ff <= CHANCE_RST;
         voice_flags_ff <= FLAGS_RST;
         pitch_mode_ff  <= MODE_RST;
         pitch_word_ff  <= PWORD_RST;
         note_word_ff   <= NWORD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_STEP_COUNT:  step_count_ff  <= csr_wdata[STEP_CSR_W-1:0];
            CSR_PULSE_COUNT: pulse_count_ff <= csr_wdata[PULSE_CSR_W-1:0];
            CSR_ROTATE_TURN: rotate_turn_ff <= csr_wdata[TURN_W-1:0];
            CSR_FIRE_CHANCE: fire_chance_ff <= csr_wdata[CHANCE_W-1:0];
            CSR_VOICE_FLAGS: voice_flags_ff <= csr_wdata[FLAGS_W-1:0];
            CSR_PITCH_MODE:  pitch_mode_ff  <= csr_wdata[MODE_W-1:0];
            CSR_PITCH_WORD:  pitch_word_ff  <= csr_wdata[PWORD_W-1:0];
            CSR_NOTE_WORD:   note_word_ff   <= csr_wdata[NWORD_W-1:0];
            default:         step_count_ff  <= step_count_ff;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff        <= req_tdata[BEAT_W-1:0];
         any_solo_ff   <= req_tdata[BEAT_W];
         ref_pitch_ff  <= req_tdata[BEAT_W+1 +: PITCH_W];
         chance_rnd_ff <= req_tdata[BEAT_W+1+PITCH_W +: RAND_W];
         pitch_rnd_ff  <= req_tdata[BEAT_W+1+PITCH_W+RAND_W +: RAND_W];
      end
      if (mult_en) begin
         rot_prod_ff <= ROT_W'(rotate_turn_ff) * ROT_W'(steps);
      end
      if (sum_en) begin
         ibeat_ff <= ibeat_in;
      end
      if (idx_load) begin
         idx_ff <= STEP_W'(mod_rem);
      end
      if (fire_load) begin
         // Onset at index zero or a Bresenham remainder below pulses, if the chance test passes
         fire_ff <= ((idx_ff == '0) || (mod_rem < REM_W'(pulses)))
                 && (CHANCE_W'(chance_rnd_ff) < fire_chance_ff);
      end
      if (emit_load) begin
         rsp_tdata_ff <= RSP_DATA_W'({note_word_ff[PITCH_W-1:0], note_pitch, note_channel});
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_beat_ff  <= '0;
         beat_seen_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Advance the last beat only on a new, ungated beat
         if (beat_new) begin
            last_beat_ff <= ibeat_ff;
            beat_seen_ff <= 1'b1;
         end
         // Hold the result until taken
         if (emit_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

>>> design/erp_checker.sv
module erp_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [erp_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import erp_pkg::*;

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Reset drops any pending result
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result still valid after reset");

   // One beat in work at a time
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("input ready right after a beat was taken");

   // No result can rise while a newly taken beat is in ST_MULT or ST_SUM
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !$rose(rsp_tvalid) ##1 !$rose(rsp_tvalid))
      else $error("result appeared too soon after a beat");

endmodule

bind euclidean_rhythm_trigger erp_checker u_erp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
